FILE: hdl/sbr_pkg.sv
// Shared types and constants for the stream byte reassembler.
// No dependencies; imported by the front, queue, back and top-level modules.
package sbr_pkg;

    localparam int POS_W  = 64;
    localparam int SLOT_W = 6;   // wide enough for a window of up to 64 entries
    localparam int CNT_W  = 7;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // one command from the front part to the back part
    typedef struct packed {
        logic        do_store;
        slot_t       slot;
        logic [7:0]  data;
        logic        is_flush;
        logic        fin;
        pos_t        end_pos;
    } cmd_t;

    // state of the back part that the front needs for classification
    typedef struct packed {
        pos_t  next_position;
        slot_t next_slot;
        logic  flush_done;
    } back_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_COUNT,
        B_FINAL,
        B_READ,
        B_LOAD
    } back_state_t;

endpackage

FILE: hdl/sbr_front.sv
// Front part: accepts items, latches the window edge and classifies each byte.
// Depends on sbr_pkg.
module sbr_front
    import sbr_pkg::*;
#(
    parameter int WINDOW = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  pos_t         byte_position,
    input  logic [7:0]   byte_value,
    input  logic         has_byte,
    input  logic         segment_end,
    input  logic         final_segment,
    input  cnt_t         space_free,
    input  back_status_t bstat,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_cmd
);

    logic       inside_reg, inside_next;
    logic       busy_reg, busy_next;
    pos_t       edge_reg, edge_next;
    cnt_t       cap;
    logic [POS_W:0] sum;
    pos_t       edge_first, edge_use, diff;
    logic [SLOT_W:0] slot_sum, slot_fix;
    logic       in_win, accept;

    // a pending flush moves next_position, so hold the input until it is done
    assign full   = q_full || busy_reg;
    assign accept = push && !full;

    always_comb
    begin
        cap        = (space_free > CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : space_free;
        sum        = {1'b0, bstat.next_position} + (POS_W+1)'(cap);
        edge_first = sum[POS_W] ? '1 : sum[POS_W-1:0];
        edge_use   = inside_reg ? edge_reg : edge_first;
        in_win     = has_byte && (byte_position >= bstat.next_position)
                     && (byte_position < edge_use);
        diff       = byte_position - bstat.next_position;
        slot_sum   = {1'b0, bstat.next_slot} + (SLOT_W+1)'(diff[CNT_W-1:0]);
        slot_fix   = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
                     slot_sum - (SLOT_W+1)'(WINDOW) : slot_sum;
    end

    always_comb
    begin
        q_push         = accept;
        q_cmd.do_store = in_win;
        q_cmd.slot     = slot_fix[SLOT_W-1:0];
        q_cmd.data     = byte_value;
        q_cmd.is_flush = segment_end;
        q_cmd.fin      = final_segment;
        q_cmd.end_pos  = has_byte ? byte_position + POS_W'(1) : byte_position;
    end

    always_comb
    begin
        inside_next = inside_reg;
        edge_next   = edge_reg;
        busy_next   = busy_reg;
        if (bstat.flush_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            edge_next   = edge_use;
            inside_next = !segment_end;
            if (segment_end)
            begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            busy_reg   <= 1'b0;
            edge_reg   <= '0;
        end
        else
        begin
            inside_reg <= inside_next;
            busy_reg   <= busy_next;
            edge_reg   <= edge_next;
        end
    end

endmodule

FILE: hdl/sbr_cmd_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on sbr_pkg.
module sbr_cmd_queue
    import sbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic q_empty
);

    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_cmd  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_en)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

FILE: hdl/sbr_back.sv
// Back part: ring buffer with valid marks, flush walker and output register.
// Depends on sbr_pkg.
module sbr_back
    import sbr_pkg::*;
#(
    parameter int WINDOW = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    input  logic         q_empty,
    output logic         q_pop,
    output back_status_t bstat,
    output logic         empty,
    input  logic         pop,
    output logic [7:0]   out_byte,
    output logic         out_valid,
    output logic         run_last,
    output logic         stream_closed,
    output cnt_t         pending_bytes
);

    localparam int SW = $clog2(WINDOW);

    back_state_t state_reg, state_next;

    logic [7:0]  ring_data [WINDOW];
    logic [7:0]  rd_data_reg;
    logic        valid_reg [WINDOW];

    pos_t  next_pos_reg, scan_pos_reg, end_pos_reg, cmd_end_reg;
    slot_t next_slot_reg, scan_slot_reg;
    cnt_t  cnt_reg, rem_reg, held_reg, pend_reg;
    logic  end_known_reg, closed_reg, fin_reg, done_reg;

    logic  out_full_reg;
    logic [7:0] ob_reg;
    logic  ov_reg, ol_reg, oc_reg;
    cnt_t  op_reg;

    logic  load_ok, scan_go;
    logic  ek_new;
    pos_t  ep_new;

    function automatic slot_t slot_inc(pos_t p, slot_t s);
        // slot follows position mod WINDOW, including the wrap at 2^64
        if (p == '1)
            return '0;
        else if (s == SLOT_W'(WINDOW - 1))
            return '0;
        else
            return s + SLOT_W'(1);
    endfunction

    assign load_ok = !out_full_reg || pop;
    assign scan_go = valid_reg[scan_slot_reg[SW-1:0]] && (cnt_reg < CNT_W'(WINDOW));
    assign ek_new  = end_known_reg || fin_reg;
    assign ep_new  = fin_reg ? cmd_end_reg : end_pos_reg;

    assign bstat.next_position = next_pos_reg;
    assign bstat.next_slot     = next_slot_reg;
    assign bstat.flush_done    = done_reg;

    assign empty         = !out_full_reg;
    assign out_byte      = ob_reg;
    assign out_valid     = ov_reg;
    assign run_last      = ol_reg;
    assign stream_closed = oc_reg;
    assign pending_bytes = op_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && cmd.is_flush)
                    state_next = B_COUNT;
            end
            B_COUNT:
            begin
                if (!scan_go)
                    state_next = B_FINAL;
            end
            B_FINAL:
            begin
                state_next = (cnt_reg == '0) ? B_LOAD : B_READ;
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                if (load_ok)
                    state_next = (rem_reg == '0) ? B_IDLE : B_READ;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == B_IDLE) && !q_empty;
    end

    // ring data memory
    always_ff @(posedge clk)
    begin
        if (q_pop && cmd.do_store)
        begin
            ring_data[cmd.slot[SW-1:0]] <= cmd.data;
        end
        if (state_reg == B_READ)
        begin
            rd_data_reg <= ring_data[next_slot_reg[SW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            for (int i = 0; i < WINDOW; i++)
                valid_reg[i] <= 1'b0;
            next_pos_reg  <= '0;
            next_slot_reg <= '0;
            scan_pos_reg  <= '0;
            scan_slot_reg <= '0;
            end_pos_reg   <= '0;
            cmd_end_reg   <= '0;
            end_known_reg <= 1'b0;
            closed_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            held_reg      <= '0;
            pend_reg      <= '0;
            out_full_reg  <= 1'b0;
            ob_reg        <= '0;
            ov_reg        <= 1'b0;
            ol_reg        <= 1'b0;
            oc_reg        <= 1'b0;
            op_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (pop && out_full_reg)
                out_full_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (cmd.do_store && !valid_reg[cmd.slot[SW-1:0]])
                        begin
                            valid_reg[cmd.slot[SW-1:0]] <= 1'b1;
                            held_reg <= held_reg + CNT_W'(1);
                        end
                        fin_reg       <= cmd.fin;
                        cmd_end_reg   <= cmd.end_pos;
                        scan_pos_reg  <= next_pos_reg;
                        scan_slot_reg <= next_slot_reg;
                        cnt_reg       <= '0;
                    end
                end
                B_COUNT:
                begin
                    if (scan_go)
                    begin
                        cnt_reg       <= cnt_reg + CNT_W'(1);
                        scan_pos_reg  <= scan_pos_reg + POS_W'(1);
                        scan_slot_reg <= slot_inc(scan_pos_reg, scan_slot_reg);
                    end
                end
                B_FINAL:
                begin
                    end_known_reg <= ek_new;
                    end_pos_reg   <= ep_new;
                    closed_reg    <= closed_reg || (ek_new && scan_pos_reg == ep_new);
                    pend_reg      <= held_reg - cnt_reg;
                    rem_reg       <= cnt_reg;
                end
                B_READ:
                begin
                    valid_reg[next_slot_reg[SW-1:0]] <= 1'b0;
                    next_pos_reg  <= next_pos_reg + POS_W'(1);
                    next_slot_reg <= slot_inc(next_pos_reg, next_slot_reg);
                    if (held_reg != '0)
                        held_reg <= held_reg - CNT_W'(1);
                    rem_reg <= rem_reg - CNT_W'(1);
                end
                B_LOAD:
                begin
                    if (load_ok)
                    begin
                        out_full_reg <= 1'b1;
                        ob_reg <= (cnt_reg == '0) ? 8'd0 : rd_data_reg;
                        ov_reg <= (cnt_reg != '0);
                        ol_reg <= (rem_reg == '0);
                        oc_reg <= closed_reg;
                        op_reg <= pend_reg;
                        if (rem_reg == '0)
                            done_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: hdl/stream_byte_reassembler_unit.sv
// Stream byte reassembler, top level: front classifier, command queue and back part.
// Depends on sbr_pkg, sbr_front, sbr_cmd_queue and sbr_back.
//
// Takes one stream byte per item, tagged with its position, and on each segment end
// delivers every in-order byte then available, each result carrying the closed flag and
// pending count after that flush (a single status-only result if none is ready). A
// byte item is taken whenever full is low. A segment end holds off the next item while
// the flush walker runs: it scans the valid marks once, one slot a cycle, and then
// reads each byte of the run from the ring memory into the output register, waiting
// on pop while that register is full. New items are held off (full) from a segment
// end until its flush is complete.
module stream_byte_reassembler_unit
    import sbr_pkg::*;
#(
    parameter int WINDOW = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] byte_position,
    input  logic [7:0]  byte_value,
    input  logic        has_byte,
    input  logic        segment_end,
    input  logic        final_segment,
    input  logic [6:0]  space_free,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        run_last,
    output logic        stream_closed,
    output logic [6:0]  pending_bytes
);

    back_status_t bstat;
    cmd_t         f_cmd, b_cmd;
    logic         q_push, q_full, q_pop, q_empty;

    sbr_front #(.WINDOW(WINDOW)) u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .byte_position (byte_position),
        .byte_value    (byte_value),
        .has_byte      (has_byte),
        .segment_end   (segment_end),
        .final_segment (final_segment),
        .space_free    (space_free),
        .bstat         (bstat),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (f_cmd)
    );

    sbr_cmd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (f_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (b_cmd),
        .q_empty (q_empty)
    );

    sbr_back #(.WINDOW(WINDOW)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (b_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .bstat         (bstat),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .run_last      (run_last),
        .stream_closed (stream_closed),
        .pending_bytes (pending_bytes)
    );

endmodule

FILE: hdl/sbr_checker.sv
// Port-level checker for the stream byte reassembler, bound to the top level.
// Depends on stream_byte_reassembler_unit.
module sbr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       run_last,
    input logic       stream_closed,
    input logic [6:0] pending_bytes
);

    logic seen_closed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_closed_reg <= 1'b0;
        else if (!empty && pop && stream_closed)
            seen_closed_reg <= 1'b1;
    end

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_valid)
                              && $stable(run_last)))
        else $error("result changed before transfer");

    // a status-only result always ends its run and carries a zero byte
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_valid) |-> (run_last && out_byte == 8'd0))
        else $error("malformed status-only result");

    // once closed, the stream stays closed
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && seen_closed_reg) |-> stream_closed)
        else $error("stream reopened");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_bytes <= 7'd64))
        else $error("pending count beyond window");

endmodule

bind stream_byte_reassembler_unit sbr_checker u_sbr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .run_last      (run_last),
    .stream_closed (stream_closed),
    .pending_bytes (pending_bytes)
);
